/* sv/jnef_pkg.sv */
// Shared constants for the JSON nesting end finder: field widths,
// status codes and the JSON delimiter bytes. No dependencies.
`default_nettype none

package jnef_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int MAX_LEN   = 4096;

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int LEN_W   = 13;
  localparam int STAT_W  = 2;
  localparam int BYTE_W  = 8;

  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;

  localparam logic [STAT_W-1:0] ST_OPEN = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERR  = 2'd2;
  localparam logic [STAT_W-1:0] ST_IDLE = 2'd3;

  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

  typedef logic [MAX_DEPTH-1:0] stack_t;

endpackage

`default_nettype wire

/* sv/json_nesting_end_finder.sv */
// JSON nesting end finder: scans one JSON value a byte per word and reports
// where its outermost bracket closes. Depends on jnef_pkg.
//
// Usage:
//   Input stream: one text byte per word in s_axis_tdata[7:0]; s_axis_tuser[0]
//   marks the first byte of a value, which must be '{' or '['. A start while
//   a scan runs abandons that scan.
//   Output stream: one result word per input word, status in m_axis_tdata[1:0]
//   (0 open, 1 complete, 2 error, 3 idle) and byte count in [14:2].
//   Each byte passes the input register, then the result register. Throughput is
//   one byte per clock while the receiver keeps up; the whole decision for a byte
//   fits between the two registers, and the bracket kinds sit in a shift-register
//   stack whose top is always bit 0, so a closer is checked without a memory read.
//   Errors: bad first byte, zero byte, mismatched or unopened closer, nesting
//   beyond MAX_DEPTH, or MAX_LEN bytes without completion. After complete or
//   error every word reports idle with length 0 until the next start.
//   Reset clears the scan state and both valid flags; the stack needs none.
//   When the receiver stalls, the result word holds and the input register
//   fills; s_axis_tready drops only once both are occupied.
`default_nettype none

module json_nesting_end_finder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [jnef_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [jnef_pkg::IN_USER_W-1:0]  s_axis_tuser,   // [0] start_req
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [jnef_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [1:0] status, [14:2] length, [15] 0
);
  import jnef_pkg::*;

  // input register
  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_start_q;

  // scan state
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               inq_q, inq_d;
  logic               esc_q, esc_d;
  logic               active_q, active_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  stack_t             stack_q, stack_d;

  // result register
  logic              out_vld_q;
  logic [STAT_W-1:0] out_stat_q, stat_c;
  logic [LEN_W-1:0]  out_len_q, len_c;

  logic out_ready, adv, in_acc;
  logic push_en, pop_en, push_bit;

  assign out_ready     = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_ready;
  assign s_axis_tready = !in_vld_q || out_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic [DEPTH_W-1:0] depth_e;
    logic               inq_e, esc_e;
    logic [LEN_W-1:0]   cnt_e, cnt_n;
    logic               is_open, is_close, want, ended;

    depth_e  = in_start_q ? '0 : depth_q;
    inq_e    = in_start_q ? 1'b0 : inq_q;
    esc_e    = in_start_q ? 1'b0 : esc_q;
    cnt_e    = in_start_q ? '0 : cnt_q;
    cnt_n    = cnt_e + LEN_W'(1);
    is_open  = (in_byte_q == CH_LBRACE) || (in_byte_q == CH_LBRACK);
    is_close = (in_byte_q == CH_RBRACE) || (in_byte_q == CH_RBRACK);
    want     = (in_byte_q == CH_RBRACK);
    ended    = 1'b0;

    depth_d  = depth_q;
    inq_d    = inq_q;
    esc_d    = esc_q;
    active_d = active_q;
    cnt_d    = cnt_q;
    stat_c   = ST_OPEN;
    len_c    = cnt_n;
    push_en  = 1'b0;
    pop_en   = 1'b0;
    push_bit = (in_byte_q == CH_LBRACK);

    if (!in_start_q && !active_q) begin
      stat_c = ST_IDLE;
      len_c  = '0;
    end else if (in_start_q && !is_open) begin
      stat_c   = ST_ERR;
      len_c    = LEN_W'(1);
      cnt_d    = LEN_W'(1);
      depth_d  = '0;
      inq_d    = 1'b0;
      esc_d    = 1'b0;
      active_d = 1'b0;
    end else begin
      cnt_d    = cnt_n;
      depth_d  = depth_e;
      inq_d    = inq_e;
      esc_d    = esc_e;
      active_d = 1'b1;
      if (in_byte_q == CH_NUL) begin
        ended  = 1'b1;
        stat_c = ST_ERR;
      end else if (inq_e) begin
        if (esc_e) begin
          esc_d = 1'b0;
        end else if (in_byte_q == CH_BSLASH) begin
          esc_d = 1'b1;
        end else if (in_byte_q == CH_QUOTE) begin
          inq_d = 1'b0;
        end
      end else if (in_byte_q == CH_QUOTE) begin
        inq_d = 1'b1;
      end else if (is_open) begin
        if (depth_e >= DEPTH_W'(MAX_DEPTH)) begin
          ended  = 1'b1;
          stat_c = ST_ERR;
        end else begin
          push_en = 1'b1;
          depth_d = depth_e + DEPTH_W'(1);
        end
      end else if (is_close) begin
        // top of stack is bit 0; a fresh start has depth 0 so it is unused
        if (depth_e == '0 || stack_q[0] != want) begin
          ended  = 1'b1;
          stat_c = ST_ERR;
        end else begin
          pop_en  = 1'b1;
          depth_d = depth_e - DEPTH_W'(1);
          if (depth_e == DEPTH_W'(1)) begin
            ended  = 1'b1;
            stat_c = ST_DONE;
          end
        end
      end
      if (!ended && cnt_n >= LEN_W'(MAX_LEN)) begin
        ended  = 1'b1;
        stat_c = ST_ERR;
      end
      if (ended) begin
        active_d = 1'b0;
      end
    end
  end

  always_comb begin
    stack_d = stack_q;
    if (push_en) begin
      stack_d = (stack_q << 1) | stack_t'(push_bit);
    end else if (pop_en) begin
      stack_d = stack_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      depth_q   <= '0;
      inq_q     <= 1'b0;
      esc_q     <= 1'b0;
      active_q  <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        depth_q   <= depth_d;
        inq_q     <= inq_d;
        esc_q     <= esc_d;
        active_q  <= active_d;
        cnt_q     <= cnt_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q  <= s_axis_tdata[BYTE_W-1:0];
      in_start_q <= s_axis_tuser[0];
    end
    if (adv) begin
      stack_q    <= stack_d;
      out_stat_q <= stat_c;
      out_len_q  <= len_c;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_len_q, out_stat_q};

  // checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth beyond stack size");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LEN_W'(MAX_LEN))
    else $error("byte count beyond length limit");

  a_esc_in_str: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> inq_q)
    else $error("escape pending outside a string");

  a_idle_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stat_q == ST_IDLE) |-> (out_len_q == '0))
    else $error("idle result with nonzero length");

  a_active_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && active_q && !in_start_q && !active_d) |=>
      (out_stat_q == ST_DONE || out_stat_q == ST_ERR))
    else $error("scan ended without complete or error");

endmodule

`default_nettype wire
